### hdl/float_to_fixed_decimal_text_macros.svh
// Assertion macros for the RTL files; fdt_ctrl.sv includes them.
`ifndef FLOAT_TO_FIXED_DECIMAL_TEXT_MACROS_SVH
`define FLOAT_TO_FIXED_DECIMAL_TEXT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define FDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define FDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/fdt_pkg.sv
package fdt_pkg;

  localparam int IntW      = 64;
  localparam int FracW     = 59;
  localparam int ShW       = 123;
  localparam int IntDigits = 20;
  localparam int BcdW      = 4 * IntDigits;

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_POINT = 6'd46;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  localparam logic [1:0] SEL_SIGN  = 2'd0;
  localparam logic [1:0] SEL_INT   = 2'd1;
  localparam logic [1:0] SEL_POINT = 2'd2;
  localparam logic [1:0] SEL_FRAC  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       frac_step;
    logic       guard_step;
    logic       round;
    logic       dab_step;
    logic       int_shift;
    logic       emit;
    logic       last;
    logic [1:0] sel;
  } fdt_cmd_t;

  typedef struct packed {
    logic sign;
    logic int_top_zero;
  } fdt_sts_t;

endpackage

### hdl/fdt_dp.sv
module fdt_dp #(
  parameter int FRAC_DIGITS = 5
) (
  input  logic             clk,
  input  logic [31:0]      float_bits,
  input  fdt_pkg::fdt_cmd_t cmd,
  output fdt_pkg::fdt_sts_t sts,
  output logic [5:0]       char_code,
  output logic             last_char
);

  localparam int FdW = 4 * FRAC_DIGITS;

  logic                        sign_r;
  logic [fdt_pkg::IntW-1:0]    ip_r;
  logic [fdt_pkg::FracW-1:0]   frac_r;
  logic [FdW-1:0]              fd_r;
  logic [3:0]                  guard_r;
  logic [fdt_pkg::BcdW-1:0]    bcd_r;
  logic [5:0]                  char_r;
  logic                        last_r;

  logic [7:0]                  exp_w;
  logic [6:0]                  sh_amt;
  logic [fdt_pkg::ShW-1:0]     sh_w;
  logic [fdt_pkg::FracW+3:0]   prod;
  logic [3:0]                  digit;
  logic [FdW-1:0]              fd_inc;
  logic                        carry;
  logic                        round_up;
  logic [fdt_pkg::BcdW-1:0]    bcd_adj;

  assign exp_w  = float_bits[30:23];
  assign sh_amt = 7'(exp_w - 8'd91);
  assign sh_w   = fdt_pkg::ShW'({1'b1, float_bits[22:0]}) << sh_amt;

  // Times ten as shift-and-add; the digit falls out above the binary point.
  assign prod  = ((fdt_pkg::FracW+4)'(frac_r) << 3) + ((fdt_pkg::FracW+4)'(frac_r) << 1);
  assign digit = prod[fdt_pkg::FracW+3 -: 4];

  always_comb begin
    logic c;
    c = 1'b1;
    fd_inc = fd_r;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (c) begin
        if (fd_r[4*i +: 4] == 4'd9) begin
          fd_inc[4*i +: 4] = 4'd0;
        end else begin
          fd_inc[4*i +: 4] = fd_r[4*i +: 4] + 4'd1;
          c = 1'b0;
        end
      end
    end
    carry = c;
  end

  assign round_up = (guard_r > 4'd5) ||
                    ((guard_r == 4'd5) && ((frac_r != '0) || fd_r[0]));

  always_comb begin
    for (int i = 0; i < fdt_pkg::IntDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sign_r <= float_bits[31];
      fd_r   <= '0;
      bcd_r  <= '0;
      if (exp_w < 8'd91) begin
        ip_r   <= '0;
        frac_r <= '0;
      end else if (exp_w >= 8'd191) begin
        ip_r   <= '1;
        frac_r <= '0;
      end else begin
        ip_r   <= sh_w[fdt_pkg::ShW-1 -: fdt_pkg::IntW];
        frac_r <= sh_w[fdt_pkg::FracW-1:0];
      end
    end
    if (cmd.frac_step) begin
      frac_r <= prod[fdt_pkg::FracW-1:0];
      if (cmd.guard_step) begin
        guard_r <= digit;
      end else begin
        fd_r <= (fd_r << 4) | FdW'(digit);
      end
    end
    if (cmd.round && round_up) begin
      fd_r <= fd_inc;
      ip_r <= ip_r + fdt_pkg::IntW'(carry);
    end
    if (cmd.dab_step) begin
      bcd_r <= {bcd_adj[fdt_pkg::BcdW-2:0], ip_r[fdt_pkg::IntW-1]};
      ip_r  <= ip_r << 1;
    end
    if (cmd.int_shift || (cmd.emit && cmd.sel == fdt_pkg::SEL_INT)) begin
      bcd_r <= bcd_r << 4;
    end
    if (cmd.emit) begin
      last_r <= cmd.last;
      case (cmd.sel)
        fdt_pkg::SEL_SIGN:  char_r <= fdt_pkg::CHAR_MINUS;
        fdt_pkg::SEL_INT:   char_r <= fdt_pkg::CHAR_ZERO + 6'(bcd_r[fdt_pkg::BcdW-1 -: 4]);
        fdt_pkg::SEL_POINT: char_r <= fdt_pkg::CHAR_POINT;
        fdt_pkg::SEL_FRAC: begin
          char_r <= fdt_pkg::CHAR_ZERO + 6'(fd_r[FdW-1 -: 4]);
          fd_r   <= fd_r << 4;
        end
        default:            char_r <= fdt_pkg::CHAR_POINT;
      endcase
    end
  end

  assign sts.sign         = sign_r;
  assign sts.int_top_zero = (bcd_r[fdt_pkg::BcdW-1 -: 4] == 4'd0);
  assign char_code        = char_r;
  assign last_char        = last_r;

endmodule

### hdl/fdt_ctrl.sv
`include "float_to_fixed_decimal_text_macros.svh"

module fdt_ctrl #(
  parameter int FRAC_DIGITS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fdt_pkg::fdt_sts_t sts,
  output fdt_pkg::fdt_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FRAC  = 4'd1;
  localparam logic [3:0] ST_ROUND = 4'd2;
  localparam logic [3:0] ST_DAB   = 4'd3;
  localparam logic [3:0] ST_SKIP  = 4'd4;
  localparam logic [3:0] ST_SIGN  = 4'd5;
  localparam logic [3:0] ST_INT   = 4'd6;
  localparam logic [3:0] ST_POINT = 4'd7;
  localparam logic [3:0] ST_FDIG  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_emit;

  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        cmd.frac_step  = 1'b1;
        cmd.guard_step = (cnt_r == 7'(FRAC_DIGITS));
        if (cmd.guard_step) begin
          state_nxt = ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DAB;
      end
      ST_DAB: begin
        cmd.dab_step = 1'b1;
        if (cnt_r == 7'(fdt_pkg::IntW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SKIP;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_SKIP: begin
        if (sts.int_top_zero && (cnt_r != 7'(fdt_pkg::IntDigits - 1))) begin
          cmd.int_shift = 1'b1;
          cnt_nxt       = cnt_r + 7'd1;
        end else begin
          state_nxt = sts.sign ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          cmd.sel       = fdt_pkg::SEL_SIGN;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_INT;
        end
      end
      ST_INT: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          cmd.sel       = fdt_pkg::SEL_INT;
          out_valid_nxt = 1'b1;
          if (cnt_r == 7'(fdt_pkg::IntDigits - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_POINT;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end
      end
      ST_POINT: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          cmd.sel       = fdt_pkg::SEL_POINT;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_FDIG;
        end
      end
      ST_FDIG: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          cmd.sel       = fdt_pkg::SEL_FRAC;
          cmd.last      = (cnt_r == 7'(FRAC_DIGITS - 1));
          out_valid_nxt = 1'b1;
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `FDT_ASSERT(a_cnt_bound, clk, rst_n, (cnt_r <= 7'(fdt_pkg::IntW)), "counter out of range")
  `FDT_ASSERT(a_load_starts, clk, rst_n, (in_valid && in_ready) |=> (state_r == ST_FRAC), "load did not start conversion")
  `FDT_ASSERT(a_last_ends, clk, rst_n, (cmd.emit && cmd.last) |=> (state_r == ST_IDLE && out_valid_r), "last char did not end the item")

endmodule

### hdl/float_to_fixed_decimal_text.sv
// Binary32 bit pattern in, fixed-point decimal text out, one character per
// transfer, in the form of a "%.<FRAC_DIGITS>f" conversion with round half
// to even on the last fraction digit.
// Input channel: in_float_bits with in_valid/in_ready; a transfer happens when
// both are high. in_ready is high only while no item is being worked on.
// Result channel: out_char_code (ASCII) and out_last_char, which marks the
// last character of a number, with out_valid/out_ready.
// Steps per item: a load, FRAC_DIGITS+1 fraction digit steps, a rounding
// step, shift-and-add-3 binary-to-BCD conversion of the 64-bit integer
// part (one bit a cycle), a loop that drops up to 19 leading zeros plus a
// step to leave that loop, then the characters. Leading zeros dropped and
// integer digits emitted together always make 20, so at least one integer
// digit is emitted; a minus sign comes first when the sign bit is set.
// A stalled receiver holds the current character in the output register and
// stops the sequencer before its next character; nothing is dropped. The next
// item is taken as soon as the last character has been loaded into the output register.
// Reset (rst_n low at a clock edge) returns to idle and drops any pending
// character.
module float_to_fixed_decimal_text #(
  parameter int FRAC_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_float_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_char_code,
  output logic        out_last_char
);

  // Command and status between sequencer and datapath.
  fdt_pkg::fdt_cmd_t cmd;
  fdt_pkg::fdt_sts_t sts;

  fdt_ctrl #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Decode, digit generation, rounding, BCD conversion and output register.
  fdt_dp #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_dp (
    .clk       (clk),
    .float_bits(in_float_bits),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (out_char_code),
    .last_char (out_last_char)
  );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int FRAC_DIGITS = 5;
  localparam int N_RANDOM    = 200;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [5:0] code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_float_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_char_code;
  logic        out_last_char;

  // characters still owed by the block, oldest first
  text_char_t pending_chars[$];
  int         n_errors = 0;
  longint     cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         recv_hold = 1'b0;

  // directed table: pattern, plus typed-in text where it is obvious
  typedef struct {
    logic [31:0] bits;
    string       text;
  } directed_row_t;

  directed_row_t directed_rows[$];

  float_to_fixed_decimal_text #(.FRAC_DIGITS(FRAC_DIGITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_float_bits(in_float_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  always #4 clk = ~clk;

  // Compute the decimal text of one binary32 pattern and queue its characters.
  task automatic queue_decimal_text(input logic [31:0] bits);
    int          exp_unb;
    logic [63:0] mant;
    logic [63:0] int_val;
    logic [63:0] frac_rem;
    logic [63:0] mask;
    logic [63:0] frac_digits;
    logic [63:0] digit_lim;
    logic [63:0] guard;
    logic [63:0] div;
    int          fbits;
    int          n_int;
    logic [3:0]  int_buf[20];
    text_char_t  ch;
    exp_unb     = int'(bits[30:23]) - 127;
    mant        = {40'd0, 1'b1, bits[22:0]};
    int_val     = '0;
    frac_rem    = '0;
    fbits       = 1;
    frac_digits = '0;
    digit_lim   = 1;
    n_int       = 0;
    for (int i = 0; i < FRAC_DIGITS; i++) digit_lim = digit_lim * 10;
    if (exp_unb < -36) begin
      int_val = '0;
    end else if (exp_unb >= 64) begin
      int_val = '1;
    end else if (exp_unb >= 23) begin
      int_val = mant << (exp_unb - 23);
    end else begin
      fbits = 23 - exp_unb;
      if (exp_unb >= 0) int_val = mant >> fbits;
      frac_rem = mant & ((64'd1 << fbits) - 1);
    end
    if (frac_rem != 0) begin
      mask = (64'd1 << fbits) - 1;
      for (int i = 0; i < FRAC_DIGITS; i++) begin
        frac_rem    = frac_rem * 10;
        frac_digits = frac_digits * 10 + (frac_rem >> fbits);
        frac_rem    = frac_rem & mask;
      end
      frac_rem = frac_rem * 10;
      guard    = frac_rem >> fbits;
      frac_rem = frac_rem & mask;
      // round half to even on the remaining fraction
      if (guard > 5 || (guard == 5 && (frac_rem != 0 || frac_digits[0])))
        frac_digits++;
      if (frac_digits >= digit_lim) begin
        frac_digits = 0;
        int_val++;
      end
    end
    ch.last = 1'b0;
    if (bits[31]) begin
      ch.code = fdt_pkg::CHAR_MINUS;
      pending_chars.push_back(ch);
    end
    do begin
      int_buf[n_int] = 4'(int_val % 10);
      int_val        = int_val / 10;
      n_int++;
    end while (int_val != 0 && n_int < 20);
    while (n_int > 0) begin
      n_int--;
      ch.code = fdt_pkg::CHAR_ZERO + 6'(int_buf[n_int]);
      pending_chars.push_back(ch);
    end
    ch.code = fdt_pkg::CHAR_POINT;
    pending_chars.push_back(ch);
    div = digit_lim / 10;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      ch.code = fdt_pkg::CHAR_ZERO + 6'((frac_digits / div) % 10);
      ch.last = (i == FRAC_DIGITS - 1);
      pending_chars.push_back(ch);
      if (div > 1) div = div / 10;
    end
  endtask

  // Offer one pattern and hold it until the transfer; returns at the
  // falling edge after the transfer with valid still high.
  task automatic send_float(input logic [31:0] bits);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_float_bits <= bits;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  // Wait for every owed character, then let a block pass.
  task automatic drain_block();
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // Random patterns: mostly normal numbers near the interesting exponents.
  function automatic logic [31:0] random_float();
    logic [31:0] bits;
    bits = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: bits[30:23] = 8'($urandom_range(127 - 36, 127 + 23));
      4, 5:       bits[30:23] = 8'($urandom_range(127 - 40, 127 + 70));
      6:          bits[22:0]  = 23'($urandom_range(7) << 20);
      default: ;
    endcase
    return bits;
  endfunction

  // Check every result transfer against the oldest owed character.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char code=%0d last=%0b",
                 $time, out_char_code, out_last_char);
        n_errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.code) begin
          $display("%0t: char_code expected %0d actual %0d",
                   $time, want.code, out_char_code);
          n_errors++;
        end
        if (out_last_char !== want.last) begin
          $display("%0t: last_char expected %0b actual %0b",
                   $time, want.last, out_last_char);
          n_errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off timed by the block below.
  always @(negedge clk) begin
    if (recv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    wait (rst_n);
    repeat (1500) @(negedge clk);
    recv_hold = 1'b1;
    repeat (400) @(negedge clk);
    recv_hold = 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      '{32'h0000_0000, "0.00000"},
      '{32'h8000_0000, "-0.00000"},
      '{32'h0000_0001, "0.00000"},
      '{32'h8000_0001, "-0.00000"},
      '{32'h7F80_0000, "18446744073709551615.00000"},
      '{32'hFF80_0000, "-18446744073709551615.00000"},
      '{32'h7FC0_0000, "18446744073709551615.00000"},
      '{32'h7F7F_FFFF, "18446744073709551615.00000"},
      '{32'h5F80_0000, "18446744073709551615.00000"},
      '{32'h3F80_0000, "1.00000"},
      '{32'hBF80_0000, "-1.00000"},
      '{32'h4120_0000, "10.00000"},
      '{32'h3F00_0000, "0.50000"},
      '{32'h5F7F_FFFF, ""},  // largest value below the saturation point
      '{32'h2D80_0000, ""},  // exponent -36, smallest that is not flushed
      '{32'h2D7F_FFFF, "0.00000"},
      '{32'h3727_C5AC, ""},  // near 0.00001: rounding across digits
      '{32'h3F7F_FFFF, ""},  // carry from the fraction into the integer part
      '{32'h4B7F_FFFF, ""},  // largest odd exact integer
      '{32'h3DCC_CCCD, ""},  // 0.1
      '{32'h3A83_126F, ""},  // 0.001
      '{32'h4049_0FDB, ""},  // pi
      '{32'h3E80_0000, ""},  // quarter, exact
      '{32'h3480_0000, ""}   // 2^-22, well below half of the last digit
    };

    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, no idling
    foreach (directed_rows[r]) begin
      if (directed_rows[r].text.len() != 0) begin
        text_char_t ch;
        for (int c = 0; c < directed_rows[r].text.len(); c++) begin
          ch.code = 6'(directed_rows[r].text[c]);
          ch.last = (c == directed_rows[r].text.len() - 1);
          pending_chars.push_back(ch);
        end
      end else begin
        queue_decimal_text(directed_rows[r].bits);
      end
      send_float(directed_rows[r].bits);
    end

    // random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 47 : 0;
      recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 11 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        logic [31:0] bits;
        bits = random_float();
        queue_decimal_text(bits);
        send_float(bits);
      end
    end

    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_block();

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/fdt_pkg.sv
hdl/fdt_dp.sv
hdl/fdt_ctrl.sv
hdl/float_to_fixed_decimal_text.sv
test/tb.sv
